### hw/rtl/pct_pkg.sv
package pct_pkg;

	// Request kinds carried on the mode field.
	typedef enum logic [1:0] {
		MODE_INSERT   = 2'd0,
		MODE_DELETE   = 2'd1,
		MODE_CHECK    = 2'd2,
		MODE_RESERVED = 2'd3
	} mode_t;

	// Result codes carried on the status field.
	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_PRESENT  = 3'd1,
		ST_FULL     = 3'd2,
		ST_REMOVED  = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_MATCH    = 3'd5,
		ST_MISMATCH = 3'd6
	} status_t;

	localparam int unsigned KEY_W    = 64;
	localparam int unsigned COOKIE_W = 64;

	// One table slot as held in the memory.
	typedef struct packed {
		logic                occupied;
		logic [KEY_W-1:0]    key;
		logic [COOKIE_W-1:0] cookie;
	} entry_t;

	// Finished result handed from the scan engine to the output register.
	typedef struct packed {
		logic    valid;
		status_t status;
	} result_t;

endpackage

### hw/rtl/pct_mem.sv
// Single-port slot memory with a registered read.
module pct_mem #(
	parameter int unsigned ENTRIES = 64,
	parameter int unsigned AW      = 6
) (
	input  logic            clk,
	input  logic            we,
	input  logic            re,
	input  logic [AW-1:0]   addr,
	input  pct_pkg::entry_t wdata,
	output pct_pkg::entry_t rdata
);

	pct_pkg::entry_t mem [ENTRIES];
	pct_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/pct_scan.sv
// Scan engine: clears the memory after reset, then serves one request at a
// time by reading every slot, noting the lowest hit and the lowest free slot,
// and writing back at most one slot when the result is handed over.
module pct_scan #(
	parameter int unsigned ENTRIES = 64,
	parameter int unsigned AW      = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [1:0]                   mode,
	input  logic [pct_pkg::KEY_W-1:0]    key,
	input  logic [pct_pkg::COOKIE_W-1:0] cookie_value,
	output logic                         idle,
	input  logic                         slot_free,
	output pct_pkg::result_t             result,
	output logic                         mem_we,
	output logic                         mem_re,
	output logic [AW-1:0]                mem_addr,
	output pct_pkg::entry_t              mem_wdata,
	input  pct_pkg::entry_t              mem_rdata
);

	localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t                        state_q;
	logic [AW-1:0]                 addr_q;
	logic                          issue_q;
	logic                          rvalid_s1;
	logic [AW-1:0]                 ridx_s1;
	logic                          hit_q;
	logic                          free_q;
	logic                          cmatch_q;
	logic [AW-1:0]                 hit_idx_q;
	logic [AW-1:0]                 free_idx_q;
	pct_pkg::mode_t                mode_q;
	logic [pct_pkg::KEY_W-1:0]     key_q;
	logic [pct_pkg::COOKIE_W-1:0]  cookie_q;

	logic                          accept;
	logic                          row_hit;
	logic                          row_free;
	logic                          do_write;
	logic [AW-1:0]                 wr_idx;
	pct_pkg::entry_t               wr_entry;
	pct_pkg::status_t              status_d;

	assign idle     = (state_q == S_IDLE);
	assign accept   = idle && in_valid;
	assign row_hit  = rvalid_s1 && mem_rdata.occupied && (mem_rdata.key == key_q);
	assign row_free = rvalid_s1 && !mem_rdata.occupied;

	// Outcome of the request once every slot has been seen.
	always_comb begin
		status_d = pct_pkg::ST_NOTFOUND;
		do_write = 1'b0;
		wr_idx   = hit_idx_q;
		wr_entry = '0;
		case (mode_q)
			pct_pkg::MODE_INSERT: begin
				if (hit_q) begin
					status_d = pct_pkg::ST_PRESENT;
				end else if (!free_q) begin
					status_d = pct_pkg::ST_FULL;
				end else begin
					status_d          = pct_pkg::ST_INSERTED;
					do_write          = 1'b1;
					wr_idx            = free_idx_q;
					wr_entry.occupied = 1'b1;
					wr_entry.key      = key_q;
					wr_entry.cookie   = cookie_q;
				end
			end
			pct_pkg::MODE_DELETE: begin
				if (hit_q) begin
					status_d = pct_pkg::ST_REMOVED;
					do_write = 1'b1;
				end
			end
			pct_pkg::MODE_CHECK: begin
				if (hit_q) begin
					status_d = cmatch_q ? pct_pkg::ST_MATCH : pct_pkg::ST_MISMATCH;
				end
			end
			default: begin
				status_d = pct_pkg::ST_NOTFOUND;
			end
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = addr_q;
		mem_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_SCAN: begin
				mem_re = issue_q;
			end
			S_FINISH: begin
				mem_we    = do_write && slot_free;
				mem_addr  = wr_idx;
				mem_wdata = wr_entry;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			addr_q        <= '0;
			issue_q       <= 1'b0;
			rvalid_s1     <= 1'b0;
			hit_q         <= 1'b0;
			free_q        <= 1'b0;
			result.valid  <= 1'b0;
			result.status <= pct_pkg::ST_NOTFOUND;
		end else begin
			result.valid <= 1'b0;
			rvalid_s1    <= (state_q == S_SCAN) && issue_q;
			case (state_q)
				S_CLEAR: begin
					if (addr_q == LAST) begin
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SCAN;
						addr_q  <= '0;
						issue_q <= 1'b1;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
					end
				end
				S_SCAN: begin
					if (issue_q) begin
						if (addr_q == LAST) begin
							issue_q <= 1'b0;
						end else begin
							addr_q <= addr_q + AW'(1);
						end
					end
					if (row_hit) begin
						hit_q <= 1'b1;
					end
					if (row_free) begin
						free_q <= 1'b1;
					end
					if (rvalid_s1 && (ridx_s1 == LAST)) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (slot_free) begin
						state_q       <= S_IDLE;
						result.valid  <= 1'b1;
						result.status <= status_d;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request payload and scan bookkeeping; only read under the flags above.
	always_ff @(posedge clk) begin
		ridx_s1 <= addr_q;
		if (accept) begin
			mode_q   <= pct_pkg::mode_t'(mode);
			key_q    <= key;
			cookie_q <= cookie_value;
		end
		if (state_q == S_SCAN) begin
			if (row_hit && !hit_q) begin
				hit_idx_q <= ridx_s1;
				cmatch_q  <= (mem_rdata.cookie == cookie_q);
			end
			if (row_free && !free_q) begin
				free_idx_q <= ridx_s1;
			end
		end
	end

endmodule

### hw/rtl/pointer_cookie_table_core.sv
// One request is served at a time: the next request word is accepted only once the scan,
// which reads one slot per cycle through the single port of the slot memory, has finished
// and its result has been handed to the output register.
// Reset: arst_n clears all control state, then a clearing pass marks every slot
// free; no request word is accepted until it has finished.
module pointer_cookie_table_core #(
	parameter int unsigned ENTRIES = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   mode,
	input  logic [pct_pkg::KEY_W-1:0]    key,
	input  logic [pct_pkg::COOKIE_W-1:0] cookie_value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [2:0]                   status
);

	// Address width of the slot memory; a one-slot table still needs one bit.
	localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic             idle;
	logic             slot_free;
	pct_pkg::result_t result;
	logic             mem_we;
	logic             mem_re;
	logic [AW-1:0]    mem_addr;
	pct_pkg::entry_t  mem_wdata;
	pct_pkg::entry_t  mem_rdata;
	logic             out_valid_q;
	logic [2:0]       status_q;

	// The engine works on one request at a time, so the input side is held off
	// whenever it is clearing, scanning or waiting to hand over a result.
	assign in_stall = !idle;

	// The output register can take a new result when it is empty or when its
	// current word is being taken in this cycle. This lets the engine start the
	// next scan while a finished result still waits downstream.
	assign slot_free = !out_valid_q || !out_stall;

	pct_mem #(
		.ENTRIES (ENTRIES),
		.AW      (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	pct_scan #(
		.ENTRIES (ENTRIES),
		.AW      (AW)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.mode         (mode),
		.key          (key),
		.cookie_value (cookie_value),
		.idle         (idle),
		.slot_free    (slot_free),
		.result       (result),
		.mem_we       (mem_we),
		.mem_re       (mem_re),
		.mem_addr     (mem_addr),
		.mem_wdata    (mem_wdata),
		.mem_rdata    (mem_rdata)
	);

	// Output register: the result word stays put while the far side stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.valid) begin
			status_q <= result.status;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;

endmodule

### bench/tb.sv
module tb;
	import pct_pkg::*;

	// The table size must agree with the block's parameter, as the predictor
	// keeps its own copy of every slot.
	localparam int unsigned ENTRIES    = 64;
	localparam int unsigned CLK_PERIOD = 8;

	// Keys for the random part come mostly from a fixed pool, so that the
	// same keys recur and inserts, deletes and checks actually find each other.
	// The pool is larger than the table so that it can be filled to the brim.
	localparam int unsigned KEY_POOL   = 96;
	localparam int unsigned CHURN_POOL = 8;

	// Shapes of the random runs: one pushes the table towards full, one
	// empties it again, one hammers a handful of keys with every operation.
	localparam int STYLE_FILL  = 0;
	localparam int STYLE_DRAIN = 1;
	localparam int STYLE_CHURN = 2;

	typedef struct {
		mode_t               op;
		logic [KEY_W-1:0]    key;
		logic [COOKIE_W-1:0] cookie;
	} request_t;

	// Every input of the block has a known value from time zero onwards.
	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_stall;
	logic [1:0]          mode         = MODE_INSERT;
	logic [KEY_W-1:0]    key          = '0;
	logic [COOKIE_W-1:0] cookie_value = '0;
	logic                out_valid;
	logic                out_stall    = 1'b1;
	logic [2:0]          status;

	// Requests waiting to be driven, and statuses predicted but not yet seen.
	request_t request_queue[$];
	status_t  status_due[$];

	// Words handed to the driver and words taken by the block.
	int words_queued   = 0;
	int words_accepted = 0;
	int fail_count     = 0;

	// Percentages of cycles in which the sender idles and the receiver stalls.
	int send_idle_pct  = 11;
	int recv_stall_pct = 85;

	// Set at each rising edge when the word on the request side was taken.
	logic word_taken = 1'b0;

	// Shadow copy of the table, kept in step with the accepted requests.
	bit                  tbl_used   [ENTRIES] = '{default: 1'b0};
	logic [KEY_W-1:0]    tbl_key    [ENTRIES];
	logic [COOKIE_W-1:0] tbl_cookie [ENTRIES];

	logic [KEY_W-1:0]    pool_key    [KEY_POOL];
	logic [COOKIE_W-1:0] pool_cookie [KEY_POOL];

	pointer_cookie_table_core #(
		.ENTRIES(ENTRIES)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.key         (key),
		.cookie_value(cookie_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Applies one request to the shadow table and returns the status that the
	// block must give for it. A lookup hits the lowest valid slot holding the
	// key, and an insert takes the lowest free slot. The reserved mode leaves
	// the table alone and reports not found, as does a delete or check that misses.
	function automatic status_t predict_status(input mode_t op,
			input logic [KEY_W-1:0] k, input logic [COOKIE_W-1:0] c);
		int      hit;
		int      free_slot;
		status_t st;
		hit       = -1;
		free_slot = -1;
		st        = ST_NOTFOUND;
		// Scanning downwards leaves the lowest matching and lowest free slot.
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (tbl_used[i] && tbl_key[i] == k)
				hit = i;
			if (!tbl_used[i])
				free_slot = i;
		end
		case (op)
			MODE_INSERT: begin
				// A present key keeps its original cookie.
				if (hit >= 0) begin
					st = ST_PRESENT;
				end else if (free_slot < 0) begin
					st = ST_FULL;
				end else begin
					tbl_used[free_slot]   = 1'b1;
					tbl_key[free_slot]    = k;
					tbl_cookie[free_slot] = c;
					st = ST_INSERTED;
				end
			end
			MODE_DELETE: begin
				if (hit >= 0) begin
					tbl_used[hit] = 1'b0;
					st = ST_REMOVED;
				end
			end
			MODE_CHECK: begin
				if (hit >= 0)
					st = (tbl_cookie[hit] == c) ? ST_MATCH : ST_MISMATCH;
			end
			default: begin
			end
		endcase
		return st;
	endfunction

	// Only the first ten failures are described; the rest are just counted.
	task automatic note_failure(input string what);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] %s", $time, what);
	endtask

	// Request side. A new word is put out only once the previous one has been
	// taken or the channel was idle, so a stalled word never changes. Whether
	// to idle is decided without looking at the stall, and valid is assigned
	// at most once per falling edge.
	always @(negedge clk) begin
		request_t rq;
		if (arst_n && (!in_valid || word_taken)) begin
			if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				rq = request_queue.pop_front();
				mode         <= rq.op;
				key          <= rq.key;
				cookie_value <= rq.cookie;
				in_valid     <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Both handshakes are sampled here at the rising edge. An accepted request
	// word is run through the predictor at once, so the expected statuses are
	// queued in the order in which the block took the requests. Every request,
	// the reserved mode included, yields exactly one status word.
	always @(posedge clk or negedge arst_n) begin : watch_words
		status_t want;
		if (!arst_n) begin
			word_taken <= 1'b0;
		end else begin
			word_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				status_due.push_back(predict_status(mode_t'(mode), key, cookie_value));
				words_accepted <= words_accepted + 1;
			end
			if (out_valid && !out_stall) begin
				if (status_due.size() == 0) begin
					note_failure($sformatf("status word %0d arrived with none expected",
						status));
				end else begin
					want = status_due.pop_front();
					if (status !== want)
						note_failure($sformatf("status mismatch: expected %s (%0d), got %0d",
							want.name(), want, status));
				end
			end
		end
	end

	task automatic push_request(input mode_t op, input logic [KEY_W-1:0] k,
			input logic [COOKIE_W-1:0] c);
		request_t rq;
		rq.op     = op;
		rq.key    = k;
		rq.cookie = c;
		request_queue.push_back(rq);
		words_queued++;
	endtask

	// Waits until the block has taken every queued word and, if asked, until
	// every status word has come back. It returns on a rising edge, so that
	// new words and new idling rates are set away from the driver's edge.
	task automatic settle(input bit results_too);
		while (words_accepted != words_queued || (results_too && status_due.size() != 0))
			@(negedge clk);
		@(posedge clk);
	endtask

	// Random requests in runs of varying shape. Cookies normally follow the
	// key's pool cookie, so checks mostly match; now and then a fresh cookie
	// or a key from outside the pool stirs in mismatches and misses.
	task automatic queue_random(input int count);
		int                  left_in_run;
		int                  style;
		int                  ins_pct;
		int                  del_pct;
		int                  roll;
		int                  slot;
		mode_t               op;
		logic [KEY_W-1:0]    k;
		logic [COOKIE_W-1:0] c;
		left_in_run = 0;
		style       = STYLE_FILL;
		for (int n = 0; n < count; n++) begin
			if (left_in_run == 0) begin
				style       = $urandom_range(STYLE_FILL, STYLE_CHURN);
				left_in_run = $urandom_range(30, 80);
			end
			left_in_run--;
			case (style)
				STYLE_FILL: begin
					ins_pct = 75;
					del_pct = 7;
				end
				STYLE_DRAIN: begin
					ins_pct = 15;
					del_pct = 55;
				end
				default: begin
					ins_pct = 35;
					del_pct = 30;
				end
			endcase
			roll = $urandom_range(0, 99);
			if (roll < ins_pct)
				op = MODE_INSERT;
			else if (roll < ins_pct + del_pct)
				op = MODE_DELETE;
			else if (roll < 95)
				op = MODE_CHECK;
			else
				op = MODE_RESERVED;
			slot = $urandom_range(0, (style == STYLE_CHURN) ? CHURN_POOL - 1 : KEY_POOL - 1);
			k = pool_key[slot];
			c = pool_cookie[slot];
			if ($urandom_range(0, 99) < 3)
				k = {$urandom, $urandom};
			if ($urandom_range(0, 99) < 12)
				c = {$urandom, $urandom};
			push_request(op, k, c);
		end
	endtask

	initial begin
		// The pool holds both extreme keys, so the random part meets them too.
		for (int i = 0; i < KEY_POOL; i++) begin
			pool_key[i]    = {$urandom, $urandom};
			pool_cookie[i] = {$urandom, $urandom};
		end
		pool_key[0] = '0;
		pool_key[1] = '1;

		// Reset is let go on a falling edge, well clear of the rising edge.
		// After it the block runs its clearing pass and stalls until done.
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase one: sender rarely idles, receiver mostly stalls.
		// Directed requests first. Key zero is an ordinary key, and both
		// extreme keys and cookies are stored and compared.
		push_request(MODE_INSERT,   '0, '1);
		push_request(MODE_INSERT,   '1, '0);
		push_request(MODE_CHECK,    '0, '1);
		push_request(MODE_CHECK,    '0, '0);
		push_request(MODE_CHECK,    '1, '0);
		// A second insert of a present key must not replace its cookie.
		push_request(MODE_INSERT,   '0, 64'h0000_0000_0000_0005);
		push_request(MODE_CHECK,    '0, '1);
		// The reserved mode reports not found and leaves the table alone.
		push_request(MODE_RESERVED, '0, '1);
		push_request(MODE_CHECK,    '0, '1);
		// Delete, then delete and check the now absent key.
		push_request(MODE_DELETE,   '0, '1);
		push_request(MODE_DELETE,   '0, '1);
		push_request(MODE_CHECK,    '0, '1);
		// The freed lowest slot is reused by the next insert.
		push_request(MODE_INSERT,   64'hA5A5_5A5A_F00F_0FF0, 64'h5A5A_A5A5_0FF0_F00F);
		push_request(MODE_CHECK,    64'hA5A5_5A5A_F00F_0FF0, 64'h5A5A_A5A5_0FF0_F00F);
		push_request(MODE_DELETE,   '1, '1);
		push_request(MODE_RESERVED, '1, '0);
		push_request(MODE_DELETE,   64'hA5A5_5A5A_F00F_0FF0, '0);

		// The sender holds off here until every status word is back.
		settle(1'b1);

		// Fill the now empty table in order, then keep inserting so that
		// the full case is seen, before the random runs start.
		for (int i = 0; i < ENTRIES + 6; i++)
			push_request(MODE_INSERT, pool_key[i], pool_cookie[i]);
		queue_random(230);
		settle(1'b0);

		// Phase two: the sender mostly idles, the receiver rarely stalls.
		send_idle_pct  = 85;
		recv_stall_pct = 11;
		queue_random(300);
		settle(1'b0);

		// Phase three: both sides run flat out.
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		queue_random(300);
		settle(1'b1);

		// Keep the clock running before the end, so that a stray status word would show up.
		repeat (2 * ENTRIES + 8) @(posedge clk);

		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Guard against a hang: several times the slowest expected run.
	initial begin
		#(CLK_PERIOD * 400000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
